// File: sv/ips_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_pkg
// Shared types and constants of the ignition power supervisor.
// ----------------------------------------------------------------------------
package ips_pkg;

    localparam int DEBOUNCE_RUN_DEF  = 3;
    localparam int TIMEOUT_WIDTH_DEF = 16;

    localparam int RUN_W       = 2;
    localparam int TIMEOUT_W   = 16;
    localparam int KICK_W      = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd600;
    localparam logic [KICK_W-1:0]    KICK_RESET    = 8'd130;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT_SECONDS   = 8'd0,
        CFG_KICK_PERIOD_TICKS = 8'd1
    } cfg_index_t;

    typedef struct packed {
        logic sample_level;
        logic second_strobe;
    } sample_t;

    typedef struct packed {
        logic stable_out;
        logic kick;
        logic shutdown_pulse;
        logic countdown_running;
    } result_t;

    // debounce, countdown control and keepalive state
    typedef struct packed {
        logic              last_sample;
        logic [RUN_W-1:0]  run_length;
        logic              stable_level;
        logic              settled;
        logic              counting;
        logic [KICK_W-1:0] kick_counter;
    } ctrl_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_seconds;
        logic [KICK_W-1:0]    kick_period_ticks;
    } cfg_t;

endpackage

// File: sv/ips_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_if
// Valid/ready channels for sample ticks, results and register writes.
// ----------------------------------------------------------------------------
interface ips_in_if;
    logic             valid;
    logic             ready;
    ips_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ips_out_if;
    logic             valid;
    logic             ready;
    ips_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ips_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ips_pkg::CFG_INDEX_W-1:0]    index;
    logic [ips_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/ips_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_step
// Next-state and result logic for one sample tick.
// ----------------------------------------------------------------------------
module ips_step #(
    parameter int DEBOUNCE_RUN  = ips_pkg::DEBOUNCE_RUN_DEF,
    parameter int TIMEOUT_WIDTH = ips_pkg::TIMEOUT_WIDTH_DEF
) (
    input  ips_pkg::sample_t           sample,
    input  ips_pkg::cfg_t              cfg,
    input  ips_pkg::ctrl_t             ctrl,
    input  logic [TIMEOUT_WIDTH-1:0]   seconds_left,
    output ips_pkg::ctrl_t             ctrl_next,
    output logic [TIMEOUT_WIDTH-1:0]   seconds_left_next,
    output ips_pkg::result_t           result
);

    localparam logic [ips_pkg::RUN_W-1:0] RUN_LEN = ips_pkg::RUN_W'(DEBOUNCE_RUN);
    localparam logic [31:0] SEC_MAX =
        (TIMEOUT_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TIMEOUT_WIDTH) - 32'd1);

    logic [31:0]                 timeout_wide;
    logic [TIMEOUT_WIDTH-1:0]    timeout_load;
    logic [ips_pkg::KICK_W:0]    kick_inc;
    logic                        pulse;

    assign timeout_wide = 32'(cfg.timeout_seconds);
    assign timeout_load = (timeout_wide > SEC_MAX) ? SEC_MAX[TIMEOUT_WIDTH-1:0]
                                                   : timeout_wide[TIMEOUT_WIDTH-1:0];
    assign kick_inc     = {1'b0, ctrl.kick_counter} + 1'b1;

    always_comb
    begin
        ctrl_next         = ctrl;
        seconds_left_next = seconds_left;
        pulse             = 1'b0;

        // countdown tick on the second strobe
        if (ctrl.counting && sample.second_strobe)
        begin
            if (seconds_left <= TIMEOUT_WIDTH'(1))
            begin
                seconds_left_next  = '0;
                ctrl_next.counting = 1'b0;
                pulse              = 1'b1;
            end
            else
            begin
                seconds_left_next = seconds_left - 1'b1;
            end
        end

        // debounce run
        if (sample.sample_level == ctrl.last_sample)
        begin
            if (ctrl.run_length < RUN_LEN)
            begin
                ctrl_next.run_length = ctrl.run_length + 1'b1;
            end
        end
        else
        begin
            ctrl_next.last_sample = sample.sample_level;
            ctrl_next.run_length  = ips_pkg::RUN_W'(1);
        end

        if (ctrl_next.run_length >= RUN_LEN)
        begin
            if (!ctrl.settled)
            begin
                ctrl_next.settled      = 1'b1;
                ctrl_next.stable_level = ctrl_next.last_sample;
                if (!ctrl_next.last_sample)
                begin
                    pulse = 1'b1;
                end
            end
            else if (ctrl_next.last_sample != ctrl.stable_level)
            begin
                ctrl_next.stable_level = ctrl_next.last_sample;
                if (!ctrl_next.last_sample && (cfg.timeout_seconds != '0))
                begin
                    seconds_left_next  = timeout_load;
                    ctrl_next.counting = 1'b1;
                end
                else
                begin
                    seconds_left_next  = '0;
                    ctrl_next.counting = 1'b0;
                end
            end
        end

        // keepalive period
        if (kick_inc >= {1'b0, cfg.kick_period_ticks})
        begin
            ctrl_next.kick_counter = '0;
        end
        else
        begin
            ctrl_next.kick_counter = kick_inc[ips_pkg::KICK_W-1:0];
        end
    end

    assign result.stable_out        = ctrl_next.stable_level;
    assign result.kick              = (ctrl.kick_counter == '0);
    assign result.shutdown_pulse    = pulse;
    assign result.countdown_running = ctrl_next.counting;

endmodule

// File: sv/ignition_power_supervisor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ignition_power_supervisor_core
// Debounced ignition monitor with shutdown countdown and watchdog kicks.
// ----------------------------------------------------------------------------
// an accepted sample tick is held in the input register, its result in the result register
// throughput: one sample tick per cycle unless the result channel stalls, set by the single
//   registered pass through the step logic between the input and result registers
// reset: all control state and the registers return to their defaults
//   (timeout 600 s, kick period 130 ticks); no clearing pass is needed
module ignition_power_supervisor_core #(
    parameter int DEBOUNCE_RUN  = ips_pkg::DEBOUNCE_RUN_DEF,
    parameter int TIMEOUT_WIDTH = ips_pkg::TIMEOUT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ips_in_if.sink      sample_ch,
    ips_out_if.source   result_ch,
    ips_cfg_if.sink     cfg_ch
);

    // configuration registers
    ips_pkg::cfg_t              cfg_reg;

    // input stage holds the accepted request
    logic                       in_valid_reg;
    ips_pkg::sample_t           in_data_reg;

    // supervisor state
    ips_pkg::ctrl_t             ctrl_reg;
    ips_pkg::ctrl_t             ctrl_next;
    logic [TIMEOUT_WIDTH-1:0]   seconds_left_reg;
    logic [TIMEOUT_WIDTH-1:0]   seconds_left_next;

    // result stage
    logic                       out_valid_reg;
    ips_pkg::result_t           out_data_reg;
    ips_pkg::result_t           result_next;

    logic                       advance;

    // the input stage moves on whenever the result stage is free or being drained
    assign advance         = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !in_valid_reg || advance;
    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;

    // the user must make writes only while idle; the block does not enforce this, and the port never stalls
    assign cfg_ch.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_seconds   <= ips_pkg::TIMEOUT_RESET;
            cfg_reg.kick_period_ticks <= ips_pkg::KICK_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                ips_pkg::CFG_TIMEOUT_SECONDS:
                begin
                    cfg_reg.timeout_seconds <= cfg_ch.data;
                end
                ips_pkg::CFG_KICK_PERIOD_TICKS:
                begin
                    cfg_reg.kick_period_ticks <= cfg_ch.data[ips_pkg::KICK_W-1:0];
                end
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ch.ready)
        begin
            in_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.ready && sample_ch.valid)
        begin
            in_data_reg <= sample_ch.data;
        end
    end

    // per-tick step logic
    ips_step #(
        .DEBOUNCE_RUN      (DEBOUNCE_RUN),
        .TIMEOUT_WIDTH     (TIMEOUT_WIDTH)
    ) u_step (
        .sample            (in_data_reg),
        .cfg               (cfg_reg),
        .ctrl              (ctrl_reg),
        .seconds_left      (seconds_left_reg),
        .ctrl_next         (ctrl_next),
        .seconds_left_next (seconds_left_next),
        .result            (result_next)
    );

    // state commits as the tick moves into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg         <= '0;
            seconds_left_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg         <= ctrl_next;
            seconds_left_reg <= seconds_left_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

endmodule

// File: sv/ips_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_checker
// Port-level checks of the ignition power supervisor.
// ----------------------------------------------------------------------------
module ips_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             out_valid,
    input  logic             out_ready,
    input  ips_pkg::result_t out_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // expiry stops the countdown, a settle pulse comes before any countdown
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.shutdown_pulse && out_data.countdown_running))
        else $error("shutdown pulse while countdown still running");

    // the countdown only runs with ignition off
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.countdown_running |-> !out_data.stable_out)
        else $error("countdown running with ignition on");

endmodule

bind ignition_power_supervisor_core ips_checker u_ips_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_data  (result_ch.data)
);
